### rtl/bpc_pkg.sv
// ----------------------------------------------------------------------------
// bpc_pkg
// Shared types and codes for the button press classifier.
// ----------------------------------------------------------------------------
package bpc_pkg;

	localparam int TICK_W  = 32;
	localparam int CFG_W   = 16;
	localparam int STATE_W = 3;
	localparam int EVENT_W = 2;
	localparam int INDEX_W = 2;

	// Press state codes.
	localparam logic [STATE_W-1:0] ST_IDLE        = 3'd0;
	localparam logic [STATE_W-1:0] ST_WAIT_LONG   = 3'd1;
	localparam logic [STATE_W-1:0] ST_WAIT_DOUBLE = 3'd2;
	localparam logic [STATE_W-1:0] ST_LONG        = 3'd3;
	localparam logic [STATE_W-1:0] ST_DOUBLE      = 3'd4;

	// Event codes.
	localparam logic [EVENT_W-1:0] EV_NONE   = 2'd0;
	localparam logic [EVENT_W-1:0] EV_SINGLE = 2'd1;
	localparam logic [EVENT_W-1:0] EV_DOUBLE = 2'd2;
	localparam logic [EVENT_W-1:0] EV_LONG   = 2'd3;

	// Register indexes.
	localparam logic [INDEX_W-1:0] REG_ACTIVE_LEVEL  = 2'd0;
	localparam logic [INDEX_W-1:0] REG_DEBOUNCE      = 2'd1;
	localparam logic [INDEX_W-1:0] REG_LONG_PRESS    = 2'd2;
	localparam logic [INDEX_W-1:0] REG_DOUBLE_WINDOW = 2'd3;

	typedef struct packed {
		logic             active_level;
		logic [CFG_W-1:0] debounce_ticks;
		logic [CFG_W-1:0] long_press_ticks;
		logic [CFG_W-1:0] double_window_ticks;
	} cfg_t;

	typedef struct packed {
		logic [STATE_W-1:0] press_state;
		logic               mark_load;
		logic [EVENT_W-1:0] press_event;
	} decision_t;

endpackage

### rtl/bpc_cfg_regs.sv
// ----------------------------------------------------------------------------
// bpc_cfg_regs
// Configuration register file with reset defaults.
// ----------------------------------------------------------------------------
module bpc_cfg_regs (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         cfg_we,
	input  logic [bpc_pkg::INDEX_W-1:0]  cfg_index,
	input  logic [bpc_pkg::CFG_W-1:0]    cfg_wdata,
	output bpc_pkg::cfg_t                cfg
);

	bpc_pkg::cfg_t cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.active_level        <= 1'b1;
			cfg_q.debounce_ticks      <= 16'd20;
			cfg_q.long_press_ticks    <= 16'd1000;
			cfg_q.double_window_ticks <= 16'd300;
		end else if (cfg_we) begin
			case (cfg_index)
				bpc_pkg::REG_ACTIVE_LEVEL:  cfg_q.active_level        <= cfg_wdata[0];
				bpc_pkg::REG_DEBOUNCE:      cfg_q.debounce_ticks      <= cfg_wdata;
				bpc_pkg::REG_LONG_PRESS:    cfg_q.long_press_ticks    <= cfg_wdata;
				bpc_pkg::REG_DOUBLE_WINDOW: cfg_q.double_window_ticks <= cfg_wdata;
				default: ;
			endcase
		end
	end

	assign cfg = cfg_q;

endmodule

### rtl/bpc_classify.sv
// ----------------------------------------------------------------------------
// bpc_classify
// Next-state and event decision for one poll.
// ----------------------------------------------------------------------------
module bpc_classify (
	input  bpc_pkg::cfg_t                cfg,
	input  logic [bpc_pkg::STATE_W-1:0]  press_state,
	input  logic [bpc_pkg::TICK_W-1:0]   mark_tick,
	input  logic [bpc_pkg::TICK_W-1:0]   tick_now,
	input  logic                         pin_level,
	output bpc_pkg::decision_t           decision
);

	logic                        pressed;
	logic [bpc_pkg::TICK_W-1:0]  age;
	logic                        past_debounce;
	logic                        past_long;
	logic                        past_window;

	assign pressed       = (pin_level == cfg.active_level);
	assign age           = tick_now - mark_tick;
	assign past_debounce = age > {{(bpc_pkg::TICK_W-bpc_pkg::CFG_W){1'b0}}, cfg.debounce_ticks};
	assign past_long     = age > {{(bpc_pkg::TICK_W-bpc_pkg::CFG_W){1'b0}}, cfg.long_press_ticks};
	assign past_window   =
		age > {{(bpc_pkg::TICK_W-bpc_pkg::CFG_W){1'b0}}, cfg.double_window_ticks};

	always_comb begin
		decision.press_state = press_state;
		decision.mark_load   = 1'b0;
		decision.press_event = bpc_pkg::EV_NONE;
		if (past_debounce) begin
			case (press_state)
				bpc_pkg::ST_IDLE: begin
					if (pressed) begin
						decision.press_state = bpc_pkg::ST_WAIT_LONG;
						decision.mark_load   = 1'b1;
					end
				end
				bpc_pkg::ST_WAIT_LONG: begin
					if (!pressed) begin
						decision.press_state = bpc_pkg::ST_WAIT_DOUBLE;
						decision.mark_load   = 1'b1;
					end else if (past_long) begin
						decision.press_state = bpc_pkg::ST_LONG;
						decision.press_event = bpc_pkg::EV_LONG;
					end
				end
				bpc_pkg::ST_WAIT_DOUBLE: begin
					if (pressed) begin
						decision.press_state = bpc_pkg::ST_DOUBLE;
						decision.mark_load   = 1'b1;
						decision.press_event = bpc_pkg::EV_DOUBLE;
					end else if (past_window) begin
						decision.press_state = bpc_pkg::ST_IDLE;
						decision.press_event = bpc_pkg::EV_SINGLE;
					end
				end
				bpc_pkg::ST_LONG, bpc_pkg::ST_DOUBLE: begin
					if (!pressed) begin
						decision.press_state = bpc_pkg::ST_IDLE;
						decision.mark_load   = 1'b1;
					end
				end
				default: begin
					// An unused code falls back to idle and restarts the mark.
					decision.press_state = bpc_pkg::ST_IDLE;
					decision.mark_load   = 1'b1;
				end
			endcase
		end
	end

endmodule

### rtl/button_press_classifier.sv
// ----------------------------------------------------------------------------
// button_press_classifier
// Turns a stream of button polls into single, double and long press events.
// ----------------------------------------------------------------------------
// An accepted poll passes through the input register, then the result register,
// before its result word appears on the master side.
// Throughput: one poll per cycle while m_tready keeps the result register draining.
// Reset: arst_n clears the press state to idle, the mark tick to zero, both
// valid flags, and loads the register defaults (active 1, debounce 20,
// long press 1000, double window 300).
module button_press_classifier (
	input  logic        clk,
	input  logic        arst_n,
	// Configuration write port.
	input  logic        cfg_we,
	input  logic [1:0]  cfg_index,
	input  logic [15:0] cfg_wdata,
	// Poll stream in.
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [39:0] s_tdata,   // [31:0] tick_now, [32] pin_level, [39:33] zero
	// Event stream out.
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [7:0]  m_tdata    // [1:0] press_event, [7:2] zero
);

	bpc_pkg::cfg_t      cfg;
	bpc_pkg::decision_t decision;

	// Input register holding one poll.
	logic                         valid_s1;
	logic [bpc_pkg::TICK_W-1:0]   tick_s1;
	logic                         pin_s1;

	// Classifier state.
	logic [bpc_pkg::STATE_W-1:0]  press_state_q;
	logic [bpc_pkg::TICK_W-1:0]   mark_tick_q;

	// Result register.
	logic                         valid_s2;
	logic [bpc_pkg::EVENT_W-1:0]  event_s2;

	logic advance;

	// The poll in the input register moves on whenever the result register is
	// empty or is being emptied this cycle; the state updates at that moment.
	assign advance  = valid_s1 && (!valid_s2 || m_tready);
	assign s_tready = !valid_s1 || advance;

	bpc_cfg_regs u_cfg (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_wdata (cfg_wdata),
		.cfg       (cfg)
	);

	bpc_classify u_classify (
		.cfg         (cfg),
		.press_state (press_state_q),
		.mark_tick   (mark_tick_q),
		.tick_now    (tick_s1),
		.pin_level   (pin_s1),
		.decision    (decision)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_tready) begin
			valid_s1 <= s_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_tvalid && s_tready) begin
			tick_s1 <= s_tdata[31:0];
			pin_s1  <= s_tdata[32];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			press_state_q <= bpc_pkg::ST_IDLE;
			mark_tick_q   <= '0;
		end else if (advance) begin
			press_state_q <= decision.press_state;
			if (decision.mark_load) begin
				mark_tick_q <= tick_s1;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (advance) begin
			valid_s2 <= 1'b1;
		end else if (m_tready) begin
			valid_s2 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			event_s2 <= decision.press_event;
		end
	end

	assign m_tvalid = valid_s2;
	assign m_tdata  = {6'b0, event_s2};

endmodule

### verif/button_press_classifier_test.sv
// ----------------------------------------------------------------------------
// button_press_classifier_test
// Self-checking bench for the button press classifier. Poll words carry
// scripted and random button gestures under several register settings; an
// in-bench classifier predicts the event word for every accepted poll, and
// a monitor checks the event stream in order, with random sender gaps and
// receiver stalls throughout.
// ----------------------------------------------------------------------------
module button_press_classifier_test;
	timeunit 1ns;
	timeprecision 1ps;

	import bpc_pkg::*;

	// One pending poll: the tick stamp and the raw pin level.
	typedef struct packed {
		logic [TICK_W-1:0] tick;
		logic              pin;
	} poll_t;

	// Ready patterns for the event side.
	typedef enum logic [1:0] {
		RX_STREAM,
		RX_RANDOM,
		RX_ALTERNATE,
		RX_SPARSE
	} rx_mode_t;

	logic        clk       = 1'b0;
	logic        arst_n    = 1'b0;
	logic        cfg_we    = 1'b0;
	logic [1:0]  cfg_index = '0;
	logic [15:0] cfg_wdata = '0;
	logic        s_tvalid  = 1'b0;
	logic        s_tready;
	logic [39:0] s_tdata   = '0;  // [31:0] tick_now, [32] pin_level, [39:33] zero
	logic        m_tvalid;
	logic        m_tready  = 1'b0;
	logic [7:0]  m_tdata;         // [1:0] press_event, [7:2] zero

	button_press_classifier dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_wdata (cfg_wdata),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tdata   (s_tdata),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata)
	);

	// 20 ns period.
	always begin
		#10 clk = 1'b1;
		#10 clk = 1'b0;
	end

	// ------------------------------------------------------------------------
	// Bench copy of the classifier: registers, press state and mark tick.
	// ------------------------------------------------------------------------
	cfg_t               model_cfg = '{active_level: 1'b1, debounce_ticks: 16'd20,
	                                  long_press_ticks: 16'd1000,
	                                  double_window_ticks: 16'd300};
	logic [STATE_W-1:0] btn_state = ST_IDLE;
	logic [TICK_W-1:0]  last_mark = '0;

	poll_t                   poll_queue[$];       // polls not yet offered
	logic [EVENT_W-1:0]      expected_events[$];  // events owed by the block
	int unsigned             failures = 0;
	int unsigned             phase_polls;
	logic [TICK_W-1:0]       poll_tick;
	int unsigned             holdoff_requests = 0;

	// Advances the bench state by one accepted poll and returns the event
	// that the block must produce for it.
	function automatic logic [EVENT_W-1:0] classify_poll(input logic [TICK_W-1:0] tick,
	                                                     input logic pin);
		logic [TICK_W-1:0]  age;
		logic               pressed;
		logic [EVENT_W-1:0] ev;
		age     = tick - last_mark;
		pressed = (pin == model_cfg.active_level);
		ev      = EV_NONE;
		// Inside the debounce window nothing moves at all.
		if (age > 32'(model_cfg.debounce_ticks)) begin
			case (btn_state)
				ST_IDLE: begin
					if (pressed) begin
						btn_state = ST_WAIT_LONG;
						last_mark = tick;
					end
				end
				ST_WAIT_LONG: begin
					if (!pressed) begin
						btn_state = ST_WAIT_DOUBLE;
						last_mark = tick;
					end else if (age > 32'(model_cfg.long_press_ticks)) begin
						// The mark is kept on the long event.
						btn_state = ST_LONG;
						ev        = EV_LONG;
					end
				end
				ST_WAIT_DOUBLE: begin
					if (pressed) begin
						btn_state = ST_DOUBLE;
						last_mark = tick;
						ev        = EV_DOUBLE;
					end else if (age > 32'(model_cfg.double_window_ticks)) begin
						btn_state = ST_IDLE;
						ev        = EV_SINGLE;
					end
				end
				ST_LONG, ST_DOUBLE: begin
					if (!pressed) begin
						btn_state = ST_IDLE;
						last_mark = tick;
					end
				end
				default: begin
					// Unused codes fall back to idle and take a fresh mark.
					btn_state = ST_IDLE;
					last_mark = tick;
				end
			endcase
		end
		return ev;
	endfunction

	task automatic note_failure(input string what);
		failures++;
		if (failures <= 10)
			$display("[%0t] check failed: %s", $realtime, what);
	endtask

	// ------------------------------------------------------------------------
	// Poll driver. Words leave the queue in bursts of random length, with
	// random gaps between bursts; some bursts have no gap at all. A word that
	// is offered stays on the bus unchanged until the block takes it.
	// ------------------------------------------------------------------------
	int unsigned burst_left = 0;
	int unsigned gap_left   = 0;

	always @(posedge clk) begin : drive_polls
		poll_t poll;
		if (!arst_n) begin
			s_tvalid   <= 1'b0;
			burst_left <= 0;
			gap_left   <= 0;
		end else if (!s_tvalid || s_tready) begin
			if (gap_left != 0) begin
				gap_left <= gap_left - 1;
				s_tvalid <= 1'b0;
			end else if (poll_queue.size() != 0) begin
				poll = poll_queue.pop_front();
				s_tdata  <= {7'b0, poll.pin, poll.tick};
				s_tvalid <= 1'b1;
				if (burst_left <= 1) begin
					burst_left <= $urandom_range(24, 1);
					gap_left   <= ($urandom_range(2, 0) == 0) ? 0 : $urandom_range(6, 1);
				end else begin
					burst_left <= burst_left - 1;
				end
			end else begin
				s_tvalid <= 1'b0;
			end
		end
	end

	// ------------------------------------------------------------------------
	// Event receiver. The ready pattern switches between streaming, random,
	// alternating and sparse modes. A hold-off request from the stimulus
	// drops ready for a long, counted stretch so that the block backs up
	// into its input side.
	// ------------------------------------------------------------------------
	rx_mode_t    rx_mode        = RX_STREAM;
	int unsigned rx_mode_left   = 0;
	int unsigned holdoff_left   = 0;
	int unsigned holdoff_served = 0;

	always @(posedge clk) begin
		if (!arst_n) begin
			m_tready <= 1'b0;
		end else if (holdoff_left != 0) begin
			m_tready     <= 1'b0;
			holdoff_left <= holdoff_left - 1;
		end else if (holdoff_served != holdoff_requests) begin
			m_tready       <= 1'b0;
			holdoff_served <= holdoff_served + 1;
			holdoff_left   <= 80;
		end else begin
			if (rx_mode_left == 0) begin
				rx_mode      <= rx_mode_t'($urandom_range(3, 0));
				rx_mode_left <= $urandom_range(60, 10);
			end else begin
				rx_mode_left <= rx_mode_left - 1;
			end
			case (rx_mode)
				RX_STREAM:    m_tready <= 1'b1;
				RX_RANDOM:    m_tready <= ($urandom_range(3, 0) != 0);
				RX_ALTERNATE: m_tready <= ~m_tready;
				default:      m_tready <= ($urandom_range(3, 0) == 0);
			endcase
		end
	end

	// ------------------------------------------------------------------------
	// Monitor. Every accepted poll queues its predicted event; every event
	// word must match the oldest prediction, pad bits included.
	// ------------------------------------------------------------------------
	always @(posedge clk) begin : watch_streams
		logic [EVENT_W-1:0] want;
		if (arst_n) begin
			if (s_tvalid && s_tready)
				expected_events.push_back(classify_poll(s_tdata[31:0], s_tdata[32]));
			if (m_tvalid && m_tready) begin
				if (expected_events.size() == 0) begin
					note_failure($sformatf("event word 0x%02h with nothing expected",
					                       m_tdata));
				end else begin
					want = expected_events.pop_front();
					if (m_tdata !== {6'b0, want})
						note_failure($sformatf("press_event expected %0d, got word 0x%02h",
						                       want, m_tdata));
				end
			end
		end
	end

	// ------------------------------------------------------------------------
	// Stimulus helpers.
	// ------------------------------------------------------------------------
	function automatic int unsigned pick(input int unsigned lo, input int unsigned hi);
		if (hi <= lo)
			return lo;
		return $urandom_range(hi, lo);
	endfunction

	task automatic push_poll(input logic [TICK_W-1:0] tick, input logic pin);
		poll_t poll;
		poll.tick = tick;
		poll.pin  = pin;
		poll_queue.push_back(poll);
		phase_polls++;
	endtask

	// Moves the tick forward and polls with the button pressed or released.
	task automatic advance(input int unsigned step, input logic pressed);
		poll_tick += step;
		push_poll(poll_tick, pressed ? model_cfg.active_level : ~model_cfg.active_level);
	endtask

	// Holds one button level for about the given span. Half of the holds
	// start with contact bounce, in steps no longer than the debounce window.
	task automatic hold_for(input int unsigned span, input logic pressed);
		int unsigned n;
		int unsigned bounces;
		n = pick(1, 5);
		if ($urandom_range(1, 0) != 0) begin
			bounces = pick(1, 3);
			repeat (bounces)
				advance(pick(0, 32'(model_cfg.debounce_ticks)), 1'($urandom_range(1, 0)));
		end
		repeat (n)
			advance(span / n + 1, pressed);
	endtask

	// One gesture: single, double or long press, noise, or a tick jump.
	task automatic push_gesture();
		int unsigned db;
		int unsigned lp;
		int unsigned dw;
		int unsigned kind;
		int unsigned short_hold;
		int unsigned quiet;
		db    = 32'(model_cfg.debounce_ticks);
		lp    = 32'(model_cfg.long_press_ticks);
		dw    = 32'(model_cfg.double_window_ticks);
		kind  = $urandom_range(19, 0);
		short_hold = pick(db + 1, (lp > db) ? lp : db + 1);
		quiet      = pick(dw + db + 2, dw + db + 200);
		if (kind < 5) begin
			hold_for(short_hold, 1'b1);
			hold_for(quiet, 1'b0);
		end else if (kind < 10) begin
			hold_for(short_hold, 1'b1);
			hold_for(pick(db + 1, (dw > db) ? dw : db + 1), 1'b0);
			hold_for(pick(db + 1, (lp > db) ? lp : db + 1), 1'b1);
			hold_for(quiet, 1'b0);
		end else if (kind < 15) begin
			hold_for(lp + db + pick(2, 500), 1'b1);
			hold_for(pick(db + 1, db + 300), 1'b0);
		end else if (kind < 18) begin
			// Noise, with steps that straddle the debounce limit.
			repeat (pick(2, 8))
				advance(pick(0, 2 * db + 10), 1'($urandom_range(1, 0)));
		end else begin
			// A jump anywhere in the tick range, often just short of the wrap.
			if ($urandom_range(1, 0) != 0)
				poll_tick = $urandom;
			else
				poll_tick = 32'hFFFF_FFFF - pick(0, 2000);
			push_poll(poll_tick, 1'($urandom_range(1, 0)));
		end
	endtask

	// Sender pause: nothing more is offered until every event has come back.
	task automatic wait_idle();
		do
			@(negedge clk);
		while (poll_queue.size() != 0 || s_tvalid || expected_events.size() != 0);
	endtask

	task automatic write_reg(input logic [INDEX_W-1:0] idx, input logic [CFG_W-1:0] value);
		@(posedge clk);
		cfg_we    <= 1'b1;
		cfg_index <= idx;
		cfg_wdata <= value;
		case (idx)
			REG_ACTIVE_LEVEL: model_cfg.active_level        = value[0];
			REG_DEBOUNCE:     model_cfg.debounce_ticks      = value;
			REG_LONG_PRESS:   model_cfg.long_press_ticks    = value;
			default:          model_cfg.double_window_ticks = value;
		endcase
	endtask

	// Writes all four registers while the block is idle. The active level
	// write carries random upper bits, which the block must ignore.
	task automatic apply_settings(input logic level, input int unsigned db,
	                              input int unsigned lp, input int unsigned dw);
		wait_idle();
		repeat (3) @(posedge clk);
		write_reg(REG_ACTIVE_LEVEL, {15'($urandom_range(32767, 0)), level});
		write_reg(REG_DEBOUNCE, 16'(db));
		write_reg(REG_LONG_PRESS, 16'(lp));
		write_reg(REG_DOUBLE_WINDOW, 16'(dw));
		@(posedge clk);
		cfg_we <= 1'b0;
		@(negedge clk);
	endtask

	// A random phase of gestures, with one full pause halfway through.
	task automatic run_gestures(input int unsigned count);
		phase_polls = 0;
		while (phase_polls < count / 2)
			push_gesture();
		wait_idle();
		while (phase_polls < count)
			push_gesture();
	endtask

	// ------------------------------------------------------------------------
	// Main sequence.
	// ------------------------------------------------------------------------
	initial begin : stimulus
		int unsigned wait_cycles;
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// Directed part under the reset settings: debounce 20, long press
		// 1000, double window 300, active high. The first poll falls inside
		// the debounce window counted from the zero mark.
		push_poll(32'd5, 1'b1);
		// Single press: press, release, let the double window run out.
		push_poll(32'd30, 1'b1);
		push_poll(32'd40, 1'b0);
		push_poll(32'd60, 1'b0);
		push_poll(32'd100, 1'b0);
		push_poll(32'd400, 1'b0);
		// Double press, then its release.
		push_poll(32'd500, 1'b1);
		push_poll(32'd600, 1'b0);
		push_poll(32'd700, 1'b1);
		push_poll(32'd800, 1'b0);
		// Long press, held on, then released.
		push_poll(32'd900, 1'b1);
		push_poll(32'd1900, 1'b1);
		push_poll(32'd1901, 1'b1);
		push_poll(32'd2000, 1'b1);
		push_poll(32'd2100, 1'b0);
		// A single press across the tick wrap.
		push_poll(32'hFFFF_FFF0, 1'b1);
		push_poll(32'h0000_0010, 1'b0);
		push_poll(32'h0000_0030, 1'b0);
		push_poll(32'h0000_013D, 1'b0);
		// Extreme tick values.
		push_poll(32'hFFFF_FFFF, 1'b1);
		push_poll(32'h0000_0000, 1'b1);
		push_poll(32'h7FFF_FFFF, 1'b1);
		push_poll(32'h8000_0000, 1'b0);
		push_poll(32'hAAAA_AAAA, 1'b0);
		push_poll(32'h5555_5555, 1'b1);
		poll_tick = 32'h5555_5555;

		// Smallest settings: every threshold at zero, active low.
		apply_settings(1'b0, 0, 0, 0);
		run_gestures(130);
		// Largest settings.
		apply_settings(1'b1, 65535, 65535, 65535);
		run_gestures(130);
		// Tight timing, active low.
		apply_settings(1'b0, 3, 40, 25);
		run_gestures(130);
		// Back to the reset values, with a long receiver hold-off while the
		// sender keeps offering polls.
		apply_settings(1'b1, 20, 1000, 300);
		phase_polls = 0;
		while (phase_polls < 130)
			push_gesture();
		holdoff_requests++;
		// Random settings, mostly modest, once in a while anywhere in range.
		repeat (5) begin
			if ($urandom_range(3, 0) == 0)
				apply_settings(1'($urandom_range(1, 0)), $urandom_range(65535, 0),
				               $urandom_range(65535, 0), $urandom_range(65535, 0));
			else
				apply_settings(1'($urandom_range(1, 0)), $urandom_range(100, 0),
				               $urandom_range(3000, 0), $urandom_range(1000, 0));
			run_gestures(130);
		end

		// Drain, with a bound, then leave room for stray words.
		wait_cycles = 0;
		while ((poll_queue.size() != 0 || s_tvalid || expected_events.size() != 0)
		       && wait_cycles < 5000) begin
			@(negedge clk);
			wait_cycles++;
		end
		repeat (10) @(posedge clk);
		if (poll_queue.size() != 0 || expected_events.size() != 0)
			note_failure($sformatf("%0d polls unsent, %0d events never arrived",
			                       poll_queue.size(), expected_events.size()));

		if (failures == 0) begin
			$display("TB_OK");
		end else begin
			$display("TB_ERROR");
		end
		$finish;
	end

	// Watchdog, far beyond the slowest correct run.
	initial begin
		#20ms;
		$display("TB_ERROR");
		$finish;
	end

endmodule

### filelist.f
rtl/bpc_pkg.sv
rtl/bpc_cfg_regs.sv
rtl/bpc_classify.sv
rtl/button_press_classifier.sv
verif/button_press_classifier_test.sv
